FILE: design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, register indexes and helpers of the packed pixel scaler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int PIXELS_PER_BYTE = 4;
  localparam int IDX_W = 2;
  localparam int PIX_W = $clog2(PIXELS_PER_BYTE);
  localparam int COLOUR_W = 24;
  localparam int X_W = 9;
  localparam int Y_W = 8;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAL_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_TWO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_X_OFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_OFF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_OFF = 3'd7;

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    colour_t [3:0] palette;
    logic stretch;
    logic [X_W-1:0] stretch_x_off;
    logic [X_W-1:0] center_x_off;
    logic [Y_W-1:0] center_y_off;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    colour_t colour;
    logic last;
  } emit_t;

  // per channel floor((a+b)/2)
  function automatic colour_t mix(input colour_t a, input colour_t b);
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] bl;
    r = {1'b0, a[23:16]} + {1'b0, b[23:16]};
    g = {1'b0, a[15:8]} + {1'b0, b[15:8]};
    bl = {1'b0, a[7:0]} + {1'b0, b[7:0]};
    return {r[8:1], g[8:1], bl[8:1]};
  endfunction

endpackage

FILE: design/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/pps_store.sv
// ----------------------------------------------------------------------------
// pps_store
// Line store of the last stretched row, with a clear sweep after reset.
// ----------------------------------------------------------------------------
module pps_store
  import pps_pkg::*;
#(
  parameter int TARGET_LINE = 240
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [$clog2(TARGET_LINE)-1:0] rd_addr,
  input  logic                           rd_ok,
  input  logic                           wr_en,
  input  logic [$clog2(TARGET_LINE)-1:0] wr_addr,
  input  colour_t                        wr_data,
  output colour_t                        above,
  output logic                           clearing
);

  localparam int AW = $clog2(TARGET_LINE);

  logic [AW-1:0] clr_addr;
  logic rd_ok_q;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  colour_t ram_wdata;
  colour_t ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(TARGET_LINE - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (rd_en) begin
        rd_ok_q <= rd_ok;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = wr_en;
      ram_waddr = wr_addr;
      ram_wdata = wr_data;
    end
  end

  pps_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(TARGET_LINE)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  // columns beyond the line read as black
  assign above = rd_ok_q ? ram_rdata : '0;

endmodule

FILE: design/pps_cfg.sv
// ----------------------------------------------------------------------------
// pps_cfg
// Configuration register file: palette, mode and screen offsets.
// ----------------------------------------------------------------------------
module pps_cfg
  import pps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data,
  output cfg_t                 regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.palette <= '0;
      regs.stretch <= 1'b1;
      regs.stretch_x_off <= X_W'(40);
      regs.center_x_off <= X_W'(80);
      regs.center_y_off <= Y_W'(40);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAL_ZERO: regs.palette[0] <= cfg_data;
        REG_PAL_ONE: regs.palette[1] <= cfg_data;
        REG_PAL_TWO: regs.palette[2] <= cfg_data;
        REG_PAL_THREE: regs.palette[3] <= cfg_data;
        REG_STRETCH_MODE: regs.stretch <= cfg_data[0];
        REG_STRETCH_X_OFF: regs.stretch_x_off <= cfg_data[X_W-1:0];
        REG_CENTER_X_OFF: regs.center_x_off <= cfg_data[X_W-1:0];
        REG_CENTER_Y_OFF: regs.center_y_off <= cfg_data[Y_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/pps_seq.sv
// ----------------------------------------------------------------------------
// pps_seq
// Write sequencer: walks the four pixels of a byte, one screen write a cycle
// while the output is free, and drives the line store read and write-back.
// ----------------------------------------------------------------------------
module pps_seq
  import pps_pkg::*;
#(
  parameter int SOURCE_SIZE = 160,
  parameter int TARGET_LINE = 240
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           regs,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     packed_pixels,
  input  logic                           frame_start,
  input  logic                           clearing,
  input  logic                           out_free,
  output logic                           go,
  output emit_t                          emit,
  output logic                           rd_en,
  output logic [$clog2(TARGET_LINE)-1:0] rd_addr,
  output logic                           rd_ok,
  output logic                           wr_en,
  output logic [$clog2(TARGET_LINE)-1:0] wr_addr,
  output colour_t                        wr_data,
  input  colour_t                        above
);

  localparam int AW = $clog2(TARGET_LINE);
  localparam int SW = $clog2(SOURCE_SIZE);
  localparam int TRW = $clog2(TARGET_LINE + 2);

  logic busy, busy_next;
  logic [PIX_W-1:0] pix, pix_next;
  logic second, second_next;
  logic ins, ins_next;
  logic [7:0] pixels, pixels_next;
  logic [SW-1:0] src_col, src_col_next;
  logic [SW-1:0] src_row, src_row_next;
  logic [X_W-1:0] tgt_col, tgt_col_next;
  logic tgt_far, tgt_far_next;
  logic [TRW-1:0] tgt_row, tgt_row_next;
  colour_t left_col, left_col_next;
  colour_t op_col, op_col_next;

  logic accept;
  logic end_pix;
  logic [IDX_W-1:0] idx;
  colour_t colour;
  colour_t first_col;
  logic [X_W-1:0] ft_col;
  logic ft_far;
  logic [TRW-1:0] ft_row;
  logic [TRW-1:0] row_sum;
  logic [X_W:0] col_inc;
  logic [X_W:0] ft_inc;
  logic [X_W:0] ft_inc2;
  logic [SW:0] src_col_inc;
  logic [SW:0] src_row_inc;
  logic [TRW-1:0] above_row;
  logic cur_in_range;
  logic ft_in_range;

  assign idx = pixels[IDX_W*pix +: IDX_W];
  assign colour = regs.palette[idx];
  assign go = busy && out_free;
  assign accept = in_valid && !in_stall;

  always_comb begin
    col_inc = {1'b0, tgt_col} + (X_W + 1)'(1);
    row_sum = tgt_row + (src_row[0] ? TRW'(2) : TRW'(1));
    // target position of the first write of this pixel
    if (src_col == '0) begin
      ft_col = '0;
      ft_far = 1'b0;
      if (src_row == '0 || row_sum >= TRW'(TARGET_LINE)) begin
        ft_row = '0;
      end else begin
        ft_row = row_sum;
      end
    end else begin
      ft_col = col_inc[X_W-1:0];
      ft_far = tgt_far | col_inc[X_W];
      ft_row = tgt_row;
    end
    ft_inc2 = {1'b0, ft_col} + (X_W + 1)'(1);
    ft_inc = col_inc;
    first_col = src_col[0] ? mix(left_col, colour) : colour;
    above_row = (tgt_row == '0) ? TRW'(TARGET_LINE - 1) : tgt_row - TRW'(1);
    cur_in_range = !tgt_far && (tgt_col < X_W'(TARGET_LINE));
    ft_in_range = !ft_far && (ft_col < X_W'(TARGET_LINE));
    src_col_inc = {1'b0, src_col} + (SW + 1)'(1);
    src_row_inc = {1'b0, src_row} + (SW + 1)'(1);
  end

  always_comb begin
    busy_next = busy;
    pix_next = pix;
    second_next = second;
    ins_next = ins;
    pixels_next = pixels;
    src_col_next = src_col;
    src_row_next = src_row;
    tgt_col_next = tgt_col;
    tgt_far_next = tgt_far;
    tgt_row_next = tgt_row;
    left_col_next = left_col;
    op_col_next = op_col;
    end_pix = 1'b0;
    emit = '0;
    rd_en = 1'b0;
    rd_addr = tgt_col[AW-1:0];
    rd_ok = cur_in_range;
    wr_en = 1'b0;
    wr_addr = tgt_col[AW-1:0];
    wr_data = op_col;

    if (go) begin
      if (ins) begin
        // inserted row write, store data was read on the previous write
        emit.x = regs.stretch_x_off + tgt_col;
        emit.y = Y_W'(above_row);
        emit.colour = mix(above, op_col);
        wr_en = cur_in_range;
        ins_next = 1'b0;
        if (!second && src_col[0]) begin
          tgt_col_next = ft_inc[X_W-1:0];
          tgt_far_next = tgt_far | ft_inc[X_W];
          second_next = 1'b1;
        end else begin
          end_pix = 1'b1;
        end
      end else if (second) begin
        emit.x = regs.stretch_x_off + tgt_col;
        emit.y = Y_W'(tgt_row);
        emit.colour = colour;
        op_col_next = colour;
        if (src_row[0]) begin
          ins_next = 1'b1;
          rd_en = 1'b1;
        end else begin
          wr_en = cur_in_range;
          wr_data = colour;
          end_pix = 1'b1;
        end
      end else if (regs.stretch) begin
        emit.x = regs.stretch_x_off + ft_col;
        emit.y = Y_W'(ft_row);
        emit.colour = first_col;
        tgt_col_next = ft_col;
        tgt_far_next = ft_far;
        tgt_row_next = ft_row;
        op_col_next = first_col;
        rd_addr = ft_col[AW-1:0];
        rd_ok = ft_in_range;
        wr_addr = ft_col[AW-1:0];
        wr_data = first_col;
        if (src_row[0]) begin
          ins_next = 1'b1;
          rd_en = 1'b1;
        end else begin
          wr_en = ft_in_range;
          if (src_col[0]) begin
            tgt_col_next = ft_inc2[X_W-1:0];
            tgt_far_next = ft_far | ft_inc2[X_W];
            second_next = 1'b1;
          end else begin
            end_pix = 1'b1;
          end
        end
      end else begin
        emit.x = regs.center_x_off + X_W'(src_col);
        emit.y = regs.center_y_off + Y_W'(src_row);
        emit.colour = colour;
        end_pix = 1'b1;
      end
    end

    if (end_pix) begin
      second_next = 1'b0;
      if (regs.stretch) begin
        left_col_next = colour;
      end
      if (src_col_inc >= (SW + 1)'(SOURCE_SIZE)) begin
        src_col_next = '0;
        if (src_row_inc >= (SW + 1)'(SOURCE_SIZE)) begin
          src_row_next = '0;
        end else begin
          src_row_next = src_row_inc[SW-1:0];
        end
      end else begin
        src_col_next = src_col_inc[SW-1:0];
      end
      pix_next = pix + PIX_W'(1);
      if (pix == PIX_W'(PIXELS_PER_BYTE - 1)) begin
        emit.last = 1'b1;
        busy_next = 1'b0;
      end
    end

    if (accept) begin
      busy_next = 1'b1;
      pix_next = '0;
      second_next = 1'b0;
      ins_next = 1'b0;
      pixels_next = packed_pixels;
      if (frame_start) begin
        src_col_next = '0;
        src_row_next = '0;
      end
    end
  end

  // a new byte enters in the cycle the last write of the previous one leaves
  assign in_stall = clearing
                    || (busy && !(go && end_pix && pix == PIX_W'(PIXELS_PER_BYTE - 1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pix <= '0;
      second <= 1'b0;
      ins <= 1'b0;
      src_col <= '0;
      src_row <= '0;
      tgt_col <= '0;
      tgt_far <= 1'b0;
      tgt_row <= '0;
      left_col <= '0;
    end else begin
      busy <= busy_next;
      pix <= pix_next;
      second <= second_next;
      ins <= ins_next;
      src_col <= src_col_next;
      src_row <= src_row_next;
      tgt_col <= tgt_col_next;
      tgt_far <= tgt_far_next;
      tgt_row <= tgt_row_next;
      left_col <= left_col_next;
    end
  end

  always_ff @(posedge clk) begin
    pixels <= pixels_next;
    op_col <= op_col_next;
  end

endmodule

FILE: design/packed_pixel_one_and_half_scaler.sv
// ----------------------------------------------------------------------------
// packed_pixel_one_and_half_scaler
// Palette expansion of 2-bit packed pixels with a 1.5x blended stretch.
// ----------------------------------------------------------------------------
// Each input byte makes one screen write per cycle while the output is free:
// one write per pixel in centre mode, and in stretch mode 1 or 2 row writes
// per pixel, each followed by an inserted-row write on odd source rows. The
// next byte is taken in the cycle the last write of the current one enters
// the output register, so the single output write per cycle sets the rate.
// The inserted-row pixel needs the line store read issued with the row write
// before it. After reset the line store is swept to zero; in_stall stays
// high during the sweep, while configuration writes are taken.
module packed_pixel_one_and_half_scaler
  import pps_pkg::*;
#(
  parameter int SOURCE_SIZE = 160,
  parameter int TARGET_LINE = 240
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           packed_pixels,
  input  logic                 frame_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [X_W-1:0]       screen_x,
  output logic [Y_W-1:0]       screen_y,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data
);

  localparam int AW = $clog2(TARGET_LINE);

  cfg_t regs;
  emit_t emit;
  logic go;
  logic out_free;
  logic clearing;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic rd_ok;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  colour_t wr_data;
  colour_t above;

  pps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .regs     (regs)
  );

  pps_store #(
    .TARGET_LINE(TARGET_LINE)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_ok   (rd_ok),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .above   (above),
    .clearing(clearing)
  );

  pps_seq #(
    .SOURCE_SIZE(SOURCE_SIZE),
    .TARGET_LINE(TARGET_LINE)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .regs         (regs),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .packed_pixels(packed_pixels),
    .frame_start  (frame_start),
    .clearing     (clearing),
    .out_free     (out_free),
    .go           (go),
    .emit         (emit),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_ok        (rd_ok),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .above        (above)
  );

  // output register, loaded whenever the sequencer makes a write
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      screen_x <= emit.x;
      screen_y <= emit.y;
      red <= emit.colour[23:16];
      green <= emit.colour[15:8];
      blue <= emit.colour[7:0];
      last <= emit.last;
    end
  end

endmodule

FILE: design/pps_chk.sv
// ----------------------------------------------------------------------------
// pps_chk
// Port-level checks of the packed pixel scaler, bound to the top level.
// ----------------------------------------------------------------------------
module pps_chk
  import pps_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [X_W-1:0]       screen_x,
  input logic [Y_W-1:0]       screen_y,
  input logic [7:0]           red,
  input logic [7:0]           green,
  input logic [7:0]           blue,
  input logic                 last
);

  // a stalled write keeps its valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  // a stalled write keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(screen_x) && $stable(screen_y) && $stable(red)
      && $stable(green) && $stable(blue) && $stable(last))
    else $error("output payload changed while stalled");

  // line store sweep holds off input right after reset
  assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during line store clear");

  // every byte makes at least four writes, so two bytes never enter back to back
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("byte accepted before previous byte finished");

endmodule

bind packed_pixel_one_and_half_scaler pps_chk u_pps_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .screen_x     (screen_x),
  .screen_y     (screen_y),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .last         (last)
);

FILE: test/packed_pixel_one_and_half_scaler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_pixel_one_and_half_scaler_tb
// Drives packed 2-bit pixel bytes through the scaler and checks every screen
// write against a cycle-free model of the palette lookup, the 1.5x blended
// stretch with its line store, and the centred copy.
// ----------------------------------------------------------------------------
module packed_pixel_one_and_half_scaler_tb;
  import pps_pkg::*;

  localparam int SOURCE_SIZE = 160;
  localparam int TARGET_LINE = 240;
  localparam int CLK_PERIOD = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_BYTES = 110;
  localparam int ROW_BYTES = SOURCE_SIZE / PIXELS_PER_BYTE;
  localparam longint TIMEOUT_NS = 64'd1_500_000 * CLK_PERIOD;

  typedef struct packed {
    logic [7:0] pixels;
    logic starts;
  } pixel_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] packed_pixels = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [X_W-1:0] screen_x;
  logic [Y_W-1:0] screen_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  packed_pixel_one_and_half_scaler #(
    .SOURCE_SIZE(SOURCE_SIZE),
    .TARGET_LINE(TARGET_LINE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .packed_pixels(packed_pixels),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .screen_x(screen_x),
    .screen_y(screen_y),
    .red(red),
    .green(green),
    .blue(blue),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // scaler shadow: configuration and stretch state
  colour_t pal [4] = '{default: '0};
  logic stretch_on = 1'b1;
  logic [X_W-1:0] sx_off = X_W'(40);
  logic [X_W-1:0] cx_off = X_W'(80);
  logic [Y_W-1:0] cy_off = Y_W'(40);
  colour_t shadow_line [TARGET_LINE] = '{default: '0};
  colour_t left_shade = '0;
  int src_col = 0;
  int src_row = 0;
  int dst_col = 0;
  int dst_row = 0;

  pixel_byte_t pending_bytes[$];
  emit_t expected_writes[$];
  int mismatches = 0;
  logic in_accepted = 1'b0;
  bit bursts_on = 1'b1;
  int hold_requests = 0;

  function automatic colour_t average_colour(input colour_t a, input colour_t b);
    colour_t m;
    logic [8:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = a[ch*8 +: 8] + b[ch*8 +: 8];
      m[ch*8 +: 8] = s[8:1];
    end
    return m;
  endfunction

  function automatic void push_write(input int x, input int y, input colour_t c);
    emit_t w;
    w.x = X_W'(x);
    w.y = Y_W'(y);
    w.colour = c;
    w.last = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // row write, plus the inserted row above it on odd source rows
  function automatic void stretch_write(input colour_t c);
    colour_t above;
    int x;
    x = sx_off + dst_col;
    push_write(x, dst_row, c);
    if ((src_row & 1) != 0) begin
      above = (dst_col < TARGET_LINE) ? shadow_line[dst_col] : '0;
      push_write(x, (dst_row == 0) ? TARGET_LINE - 1 : dst_row - 1,
                 average_colour(above, c));
    end
    if (dst_col < TARGET_LINE) shadow_line[dst_col] = c;
  endfunction

  function automatic void stretch_pixel(input colour_t c);
    if (src_col == 0) begin
      dst_col = 0;
      if (src_row == 0) dst_row = 0;
      else dst_row += ((src_row & 1) != 0) ? 2 : 1;
      if (dst_row >= TARGET_LINE) dst_row = 0;
    end else begin
      dst_col++;
    end
    if ((src_col & 1) != 0) begin
      stretch_write(average_colour(left_shade, c));
      dst_col++;
    end
    stretch_write(c);
    left_shade = c;
  endfunction

  function automatic void predict_byte(input logic [7:0] bits, input logic starts);
    colour_t c;
    emit_t tail;
    if (starts) begin
      src_col = 0;
      src_row = 0;
    end
    for (int k = 0; k < PIXELS_PER_BYTE; k++) begin
      c = pal[bits[2*k +: 2]];
      if (stretch_on) stretch_pixel(c);
      else push_write(cx_off + src_col, cy_off + src_row, c);
      src_col++;
      if (src_col >= SOURCE_SIZE) begin
        src_col = 0;
        src_row++;
        if (src_row >= SOURCE_SIZE) src_row = 0;
      end
    end
    tail = expected_writes.pop_back();
    tail.last = 1'b1;
    expected_writes.push_back(tail);
  endfunction

  // write checker and input predictor
  always @(posedge clk) begin
    emit_t want;
    in_accepted <= in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected write x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                     screen_x, screen_y, red, green, blue, last);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          if (screen_x !== want.x || screen_y !== want.y
              || {red, green, blue} !== want.colour || last !== want.last) begin
            if (mismatches < 10)
              $display({"write mismatch: expected x=%0d y=%0d rgb=%06h last=%0b,",
                        " got x=%0d y=%0d rgb=%02h%02h%02h last=%0b"},
                       want.x, want.y, want.colour, want.last,
                       screen_x, screen_y, red, green, blue, last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(packed_pixels, frame_start);
    end
  end

  // byte driver
  always @(negedge clk) begin
    pixel_byte_t nxt;
    int gap_left;
    if (!in_valid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        if (in_valid && bursts_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_bytes.pop_front();
          packed_pixels <= nxt.pixels;
          frame_start <= nxt.starts;
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // write receiver back-pressure
  always @(negedge clk) begin
    int holds_done;
    int hold_left;
    int stall_left;
    if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAL_ZERO: pal[0] = data;
      REG_PAL_ONE: pal[1] = data;
      REG_PAL_TWO: pal[2] = data;
      REG_PAL_THREE: pal[3] = data;
      REG_STRETCH_MODE: stretch_on = data[0];
      REG_STRETCH_X_OFF: sx_off = data[X_W-1:0];
      REG_CENTER_X_OFF: cx_off = data[X_W-1:0];
      REG_CENTER_Y_OFF: cy_off = data[Y_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_value(input int bits);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 24'((32'h1 << bits) - 1);
      default: return 24'($urandom() & ((32'h1 << bits) - 1));
    endcase
  endfunction

  task automatic shuffle_config();
    if ($urandom_range(0, 1)) write_reg(REG_PAL_ZERO, pick_value(COLOUR_W));
    if ($urandom_range(0, 1)) write_reg(REG_PAL_ONE, pick_value(COLOUR_W));
    if ($urandom_range(0, 1)) write_reg(REG_PAL_TWO, pick_value(COLOUR_W));
    if ($urandom_range(0, 1)) write_reg(REG_PAL_THREE, pick_value(COLOUR_W));
    if ($urandom_range(0, 1)) write_reg(REG_STRETCH_MODE, 24'($urandom_range(0, 3) != 0));
    if ($urandom_range(0, 1)) write_reg(REG_STRETCH_X_OFF, pick_value(X_W));
    if ($urandom_range(0, 1)) write_reg(REG_CENTER_X_OFF, pick_value(X_W));
    if ($urandom_range(0, 1)) write_reg(REG_CENTER_Y_OFF, pick_value(Y_W));
  endtask

  task automatic queue_byte(input logic [7:0] bits, input logic starts);
    pixel_byte_t b;
    b.pixels = bits;
    b.starts = starts;
    pending_bytes.push_back(b);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // sender pause: nothing in flight, then let the block finish its last byte
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // resume stretch mid-row from stale state: one centred byte, rest stretched
  task automatic stale_row();
    write_reg(REG_STRETCH_MODE, 24'd0);
    queue_random(1);
    wait_idle();
    write_reg(REG_STRETCH_MODE, 24'd1);
    queue_random(ROW_BYTES - 1);
    wait_idle();
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("packed_pixel_one_and_half_scaler_tb NOT OK");
    $finish;
  end

  initial begin
    int sent;
    int len;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // palette extremes so blends hit 0x00 and 0xff per channel
    write_reg(REG_PAL_ZERO, 24'h000000);
    write_reg(REG_PAL_ONE, 24'hffffff);
    write_reg(REG_PAL_TWO, 24'hff0000);
    write_reg(REG_PAL_THREE, 24'h81fe03);
    write_reg(REG_STRETCH_MODE, 24'd1);
    write_reg(REG_STRETCH_X_OFF, 24'd511);
    write_reg(REG_CENTER_X_OFF, 24'd511);
    write_reg(REG_CENTER_Y_OFF, 24'd255);

    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'he4, 1'b0);
    queue_byte(8'h1b, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'haa, 1'b0);
    // restart in mid-row
    queue_byte(8'h39, 1'b1);
    queue_byte(8'hc6, 1'b0);
    wait_idle();

    // centred copy with coordinates wrapping
    write_reg(REG_STRETCH_MODE, 24'd0);
    queue_byte(8'he4, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(REG_CENTER_X_OFF, 24'd0);
    write_reg(REG_CENTER_Y_OFF, 24'd0);
    queue_byte(8'h1b, 1'b0);
    queue_byte(8'h93, 1'b0);
    wait_idle();
    // back to stretch from the stale stretch position
    write_reg(REG_STRETCH_MODE, 24'd1);
    queue_byte(8'h6c, 1'b0);
    queue_byte(8'hb1, 1'b0);
    queue_byte(8'h4e, 1'b0);
    wait_idle();

    // two stretched rows: odd-row inserts while the receiver holds off
    write_reg(REG_STRETCH_X_OFF, 24'd40);
    write_reg(REG_PAL_THREE, 24'($urandom_range(0, 24'hffffff)));
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
    queue_random(ROW_BYTES * 2 - 1);
    hold_requests++;
    wait_idle();

    // stale columns run past the line store, on an even and then an odd row
    stale_row();
    stale_row();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= RANDOM_BYTES * 4 / 5) bursts_on = 1'b0;
      shuffle_config();
      len = $urandom_range(4, 40);
      for (int i = 0; i < len; i++)
        queue_byte(8'($urandom_range(0, 255)),
                   (i == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 29) == 0));
      if (bursts_on && $urandom_range(0, 7) == 0) hold_requests++;
      sent += len;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("packed_pixel_one_and_half_scaler_tb OK");
    end else begin
      $display("packed_pixel_one_and_half_scaler_tb NOT OK");
    end
    $finish;
  end

endmodule
